FILE: rtl/gst_pkg.sv
package gst_pkg;

    localparam int MaxGroup   = 64;
    localparam int ValueWidth = 32;
    localparam int IdxW       = $clog2(MaxGroup);
    localparam int CntW       = $clog2(MaxGroup + 1);
    localparam logic [31:0] OneQ16 = 32'd65536;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SQ    = 7'b0000010,
        S_SQRT  = 7'b0000100,
        S_MUL   = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_FACT  = 7'b0100000,
        S_EMIT  = 7'b1000000
    } t_state;

    function automatic logic [ValueWidth-1:0] mag_of(input logic [ValueWidth-1:0] v);
        return v[ValueWidth-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

FILE: rtl/group_soft_threshold_unit.sv
// Group soft-threshold unit (group lasso proximal step), Q16.16.
// Input: hold start high with an element until it is taken at an edge where
// busy is low. The element is stored and its square added to a saturating
// 64-bit sum; busy stays high until the sum is updated, so the next element
// waits. On the element flagged i_group_end, or when 64 elements are held,
// the group closes: a bit-pair square root, one multiply of lambda by weight,
// a shift-subtract divide, then one result per buffered element on o_valid,
// one per cycle, last one with o_last_of_group.
// o_group_overflow marks groups cut at the 64-entry capacity.
// When the norm is zero the divide is skipped. The receiver cannot stall:
// each result is shown for exactly one cycle. Lambda must be written via
// i_lambda_we while idle; the block itself does not enforce this.
// Reset (synchronous, active low) empties the group, clears the sum and sets
// lambda to 1.0. Buffer contents are not cleared; only written entries are read.
module group_soft_threshold_unit
    import gst_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_lambda_we,
    input  logic [31:0]           i_lambda_q16,
    input  logic [ValueWidth-1:0] i_element_value,
    input  logic [31:0]           i_group_weight,
    input  logic                  i_group_end,
    output logic                  o_valid,
    output logic [ValueWidth-1:0] o_scaled_value,
    output logic                  o_last_of_group,
    output logic                  o_group_overflow
);
    logic [ValueWidth-1:0] r_mem [MaxGroup];
    logic [ValueWidth-1:0] r_rd;

    t_state      r_state, n_state;
    logic [31:0] r_lambda;
    logic [63:0] r_sum, n_sum;
    logic [CntW-1:0] r_fill, n_fill;
    logic [CntW-1:0] r_ptr, n_ptr;
    logic [31:0] r_weight, n_weight;
    logic [ValueWidth-1:0] r_mag;
    logic        r_close, n_close, r_cut, n_cut;
    logic [63:0] r_num, n_num;
    logic [31:0] r_root, n_root;
    logic [5:0]  r_step, n_step;
    logic [31:0] r_fact, n_fact;
    logic        r_rdv, n_rdv;
    logic        r_ov, n_ov;
    logic [ValueWidth-1:0] r_out, n_out;
    logic        r_last, n_last, n_ovf, r_ovf;
    logic        div_start, div_done;
    logic [63:0] div_quo;

    logic [63:0] w_sq, w_add;
    logic        w_carry;
    logic [34:0] w_rsh;
    logic [35:0] w_trial;
    logic [63:0] w_prod;

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state; n_sum = r_sum; n_fill = r_fill; n_ptr = r_ptr;
        n_weight = r_weight; n_close = r_close; n_cut = r_cut;
        n_num = r_num; n_root = r_root; n_step = r_step; n_fact = r_fact;
        n_rdv = 1'b0; n_ov = 1'b0; n_out = r_out; n_last = r_last; n_ovf = r_ovf;
        div_start = 1'b0;
        w_sq = {32'd0, r_mag} * {32'd0, r_mag};
        {w_carry, w_add} = {1'b0, r_sum} + {1'b0, w_sq};
        w_rsh = {r_num[32:0], r_sum[63:62]};
        w_trial = {1'b0, w_rsh} - {2'b00, r_root, 2'b01};
        w_prod = {32'd0, r_lambda} * {32'd0, r_weight};
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_weight = i_group_weight;
                    n_fill = r_fill + 1'b1;
                    n_close = i_group_end || (r_fill + 1'b1 == CntW'(MaxGroup));
                    n_cut = !i_group_end;
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                n_sum = w_carry ? '1 : w_add;
                if (r_close) begin
                    n_num = '0; n_root = '0; n_step = '0;
                    n_state = S_SQRT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SQRT: begin
                // r_num[32:0] holds remainder, r_sum shifts out two bits a step
                if (!w_trial[35]) begin
                    n_num = {31'd0, w_trial[32:0]};
                    n_root = {r_root[30:0], 1'b1};
                end else begin
                    n_num = {31'd0, w_rsh[32:0]};
                    n_root = {r_root[30:0], 1'b0};
                end
                n_sum = {r_sum[61:0], 2'b00};
                n_step = r_step + 1'b1;
                if (r_step == 6'd31) n_state = S_MUL;
            end
            S_MUL: begin
                n_num = w_prod;
                if (r_root == '0) begin
                    n_fact = '0; n_ptr = '0; n_state = S_EMIT;
                end else begin
                    div_start = 1'b1; n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_fact = (div_quo < 64'(OneQ16)) ? (OneQ16 - div_quo[31:0]) : '0;
                    n_ptr = '0;
                    n_state = S_EMIT;
                end
            end
            S_FACT: n_state = S_EMIT;
            S_EMIT: begin
                if (r_ptr < r_fill) begin
                    n_rdv = 1'b1;
                    n_ptr = r_ptr + 1'b1;
                    n_last = (r_ptr + 1'b1 == r_fill);
                    n_ovf = r_cut;
                end else if (!r_rdv) begin
                    n_fill = '0; n_sum = '0; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    logic [ValueWidth-1:0] w_m;
    logic [ValueWidth+31:0] w_sp;
    logic [ValueWidth-1:0] w_r;
    always_comb begin
        w_m = mag_of(r_rd);
        w_sp = ({32'd0, w_m} * {{ValueWidth{1'b0}}, r_fact});
        w_r = w_sp[ValueWidth+15:16];
        if (r_rd[ValueWidth-1]) w_r = ~w_r + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_mem[r_fill[IdxW-1:0]] <= i_element_value;
            r_mag <= mag_of(i_element_value);
        end
        if (r_state == S_EMIT && r_ptr < r_fill) r_rd <= r_mem[r_ptr[IdxW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_lambda <= OneQ16; r_sum <= '0; r_fill <= '0;
            r_rdv <= 1'b0; r_ov <= 1'b0;
        end else begin
            r_state <= n_state; r_sum <= n_sum; r_fill <= n_fill;
            r_rdv <= n_rdv; r_ov <= r_rdv;
            if (i_lambda_we) r_lambda <= i_lambda_q16;
        end
        r_ptr <= n_ptr; r_weight <= n_weight; r_close <= n_close; r_cut <= n_cut;
        r_num <= n_num; r_root <= n_root; r_step <= n_step; r_fact <= n_fact;
        r_last <= n_last; r_ovf <= n_ovf;
        if (r_rdv) r_out <= w_r;
    end

    logic r_l2, r_o2;
    always_ff @(posedge i_clk) begin
        r_l2 <= r_last; r_o2 <= r_ovf;
    end

    gst_div u_div (
        .i_clk, .i_rst_n, .i_start(div_start), .i_num(n_num), .i_den(r_root),
        .o_done(div_done), .o_quo(div_quo)
    );

    assign o_valid = r_ov;
    assign o_scaled_value = r_out;
    assign o_last_of_group = r_l2;
    assign o_group_overflow = r_o2;
endmodule

FILE: rtl/gst_div.sv
module gst_div
    import gst_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quo
);
    // Restoring divider, one quotient bit per cycle: 64 / 32 -> 64.
    logic [63:0] r_quo, n_quo;
    logic [31:0] r_rem, n_rem;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic [32:0] w_trial;
    logic [32:0] w_diff;

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        w_trial = {r_rem, r_quo[63]};
        w_diff  = w_trial - {1'b0, i_den};
        if (i_start) begin
            n_quo  = i_num;
            n_rem  = '0;
            n_cnt  = 7'd64;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, i_den}) begin
                n_rem = w_diff[31:0];
                n_quo = {r_quo[62:0], 1'b1};
            end else begin
                n_rem = w_trial[31:0];
                n_quo = {r_quo[62:0], 1'b0};
            end
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
    end

    assign o_done = r_busy && (r_cnt == 7'd1);
    assign o_quo  = n_quo;
endmodule

FILE: rtl/gst_checker.sv
module gst_checker
    import gst_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid,
    input logic o_last_of_group
);
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("no busy after start");
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("result while idle");
    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_of_group && o_valid |=> !o_valid) else $error("result after last");
endmodule

bind group_soft_threshold_unit gst_checker u_chk (
    .i_clk, .i_rst_n, .start, .busy, .o_valid, .o_last_of_group
);
